[src/lhg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lhg_pkg
// Types, constants and elaboration-time helpers for the HRAP grid projection.
// ----------------------------------------------------------------------------
package lhg_pkg;

  localparam int CORDIC_STAGES   = 20;
  localparam int ANGLE_FRAC_BITS = 16;

  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int OUT_W  = 21;
  localparam int DEG_W  = 26;
  localparam int ANG_W  = ANGLE_FRAC_BITS + 4;
  localparam int CW     = 34;
  localparam int PROD_W = 2 * CW;
  localparam int REM_W  = 64;
  localparam int DEN_W  = 31;
  localparam int DIV_BITS = 34;
  localparam int QS_W   = DIV_BITS + 1;
  localparam int RE_W   = 29;
  localparam int V_W    = 28;
  localparam int SH_W   = 6;
  localparam int SPLIT  = 18;
  localparam int PP_W   = DEG_W + SPLIT + 1;

  localparam int SH_HALF = 40 + 17 - ANGLE_FRAC_BITS;
  localparam int SH_T    = 40 + 16 - ANGLE_FRAC_BITS;

  localparam logic signed [63:0] DEGRAD_Q40 = 64'sd19190098597;
  localparam logic signed [63:0] PI4_Q62    = 64'sd3622009729038561421;
  localparam logic signed [SPLIT:0] DEGRAD_HI = (SPLIT + 1)'(DEGRAD_Q40 >>> SPLIT);
  localparam logic signed [SPLIT:0] DEGRAD_LO =
    (SPLIT + 1)'(DEGRAD_Q40 & ((64'sd1 <<< SPLIT) - 64'sd1));

  localparam logic signed [CW-1:0]   KINV_Q30 = CW'(64'sd652032874);
  localparam logic signed [RE_W-1:0] RE_Q16   = RE_W'(64'sd163600163);

  localparam logic signed [DEG_W-1:0] DEG75  = DEG_W'(64'sd4915200);
  localparam logic signed [DEG_W-1:0] DEG90  = DEG_W'(64'sd5898240);
  localparam logic signed [DEG_W-1:0] DEG180 = DEG_W'(64'sd11796480);
  localparam logic signed [DEG_W-1:0] DEG360 = DEG_W'(64'sd23592960);

  localparam logic [DIV_BITS-1:0] QLIMIT = DIV_BITS'(64'd1 << 32);
  localparam logic signed [V_W-1:0] OUT_MAX = V_W'(64'sd1048575);
  localparam logic signed [V_W-1:0] OUT_MIN = -V_W'(64'sd1048576);
  localparam logic signed [V_W-1:0] OFF_X   = V_W'(64'sd401 * 256);
  localparam logic signed [V_W-1:0] OFF_Y   = V_W'(64'sd1601 * 256);

  typedef struct packed {
    logic                    valid;
    logic                    pole;
    logic                    neg;
    logic signed [CW-1:0]    xa;
    logic signed [CW-1:0]    ya;
    logic signed [ANG_W-1:0] za;
    logic signed [CW-1:0]    xt;
    logic signed [CW-1:0]    yt;
    logic signed [ANG_W-1:0] zt;
  } cor_t;

  typedef struct packed {
    logic                valid;
    logic                pole;
    logic [DEN_W-1:0]    den;
    logic [REM_W-1:0]    rem_x;
    logic [DIV_BITS-1:0] q_x;
    logic                sgn_x;
    logic                ovf_x;
    logic [REM_W-1:0]    rem_y;
    logic [DIV_BITS-1:0] q_y;
    logic                sgn_y;
    logic                ovf_y;
  } div_t;

  // shift-subtract divide, used only on constants
  function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in the angle format, from a Q62 series
  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [63:0] acc;
    logic signed [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = PI4_Q62;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = signed'(const_udiv(64'd1 << (62 - e), 64'(2 * k + 1)));
          acc = k[0] ? acc - term : acc + term;
        end
      end
    end
    acc = (acc + (64'sd1 <<< (61 - ANGLE_FRAC_BITS))) >>> (62 - ANGLE_FRAC_BITS);
    return acc[ANG_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/latlon_to_hrap_grid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// latlon_to_hrap_grid
// Lat/lon to HRAP polar stereographic grid, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per point: latitude and longitude in degrees,
//   16 fraction bits, west positive. m_axis returns grid x and y with 8
//   fraction bits, and tuser flags a clamped coordinate or the south pole.
//   Throughput: one point per cycle. Pipeline: 3 front stages, 20 CORDIC
//   cells (sine/cosine of half colatitude and shifted longitude), 2 stages
//   of product and sign, 34 divider cells (one quotient bit each), 2 scale
//   and clamp stages. The whole pipeline advances together; when
//   m_axis_tready is low with a result held, every stage holds and
//   s_axis_tready drops. Reset clears all valid bits; payload registers
//   are not reset.
// ----------------------------------------------------------------------------
module latlon_to_hrap_grid (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // latitude[23:0], longitude[48:24]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // grid_x[20:0], grid_y[41:21]
  output logic             m_axis_tuser   // saturated[0]
);
  import lhg_pkg::*;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // front: clamp, wrap, fold
  logic signed [LAT_W-1:0] lat_in;
  logic signed [LON_W-1:0] lon_in;
  logic signed [DEG_W-1:0] lat_e, lat_c, half_c, t0, t1, t2;
  logic neg_c;

  always_comb begin
    lat_in = signed'(s_axis_tdata[LAT_W-1:0]);
    lon_in = signed'(s_axis_tdata[LAT_W+LON_W-1:LAT_W]);
    lat_e  = DEG_W'(lat_in);
    lat_c  = lat_e;
    if (lat_e > DEG90) lat_c = DEG90;
    if (lat_e < -DEG90) lat_c = -DEG90;
    half_c = DEG90 - lat_c;
    t0 = DEG_W'(lon_in) + DEG75;
    t1 = t0;
    if (t0 > DEG180) t1 = t0 - DEG360;
    else if (t0 <= -DEG180) t1 = t0 + DEG360;
    t2 = t1;
    neg_c = 1'b0;
    if (t1 > DEG90) begin
      t2 = t1 - DEG180;
      neg_c = 1'b1;
    end else if (t1 < -DEG90) begin
      t2 = t1 + DEG180;
      neg_c = 1'b1;
    end
  end

  logic valid1, pole1, neg1;
  logic signed [DEG_W-1:0] half1, t1r;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pole1 <= (lat_c == -DEG90);
      neg1  <= neg_c;
      half1 <= half_c;
      t1r   <= t2;
    end
  end

  // degrees to radians: split constant product
  logic valid2, pole2, neg2;
  logic signed [PP_W-1:0] ph_hi, ph_lo, pt_hi, pt_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (en) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pole2 <= pole1;
      neg2  <= neg1;
      ph_hi <= PP_W'(half1 * DEGRAD_HI);
      ph_lo <= PP_W'(half1 * DEGRAD_LO);
      pt_hi <= PP_W'(t1r * DEGRAD_HI);
      pt_lo <= PP_W'(t1r * DEGRAD_LO);
    end
  end

  logic signed [63:0] ph, pt, zh, zt;
  cor_t cor [0:CORDIC_STAGES];
  cor_t cor0_next;

  always_comb begin
    ph = (64'(ph_hi) <<< SPLIT) + 64'(ph_lo);
    pt = (64'(pt_hi) <<< SPLIT) + 64'(pt_lo);
    zh = (ph + (64'sd1 <<< (SH_HALF - 1))) >>> SH_HALF;
    zt = (pt + (64'sd1 <<< (SH_T - 1))) >>> SH_T;
    cor0_next.valid = valid2;
    cor0_next.pole  = pole2;
    cor0_next.neg   = neg2;
    cor0_next.xa    = KINV_Q30;
    cor0_next.ya    = '0;
    cor0_next.za    = zh[ANG_W-1:0];
    cor0_next.xt    = KINV_Q30;
    cor0_next.yt    = '0;
    cor0_next.zt    = zt[ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cor[0].valid <= 1'b0;
    end else if (en) begin
      cor[0].valid <= cor0_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor[0].pole <= cor0_next.pole;
      cor[0].neg  <= cor0_next.neg;
      cor[0].xa   <= cor0_next.xa;
      cor[0].ya   <= cor0_next.ya;
      cor[0].za   <= cor0_next.za;
      cor[0].xt   <= cor0_next.xt;
      cor[0].yt   <= cor0_next.yt;
      cor[0].zt   <= cor0_next.zt;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    lhg_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .shift (SH_W'(g)),
      .atan  (atan_entry(g)),
      .d_in  (cor[g]),
      .d_out (cor[g+1])
    );
  end

  // products of half-angle sine with longitude sine/cosine
  logic valid_m, pole_m, neg_m;
  logic [DEN_W-1:0] den_m;
  logic signed [PROD_W-1:0] px_m, py_m;
  logic pole_c;

  assign pole_c = cor[CORDIC_STAGES].pole || (cor[CORDIC_STAGES].xa <= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m <= 1'b0;
    end else if (en) begin
      valid_m <= cor[CORDIC_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pole_m <= pole_c;
      neg_m  <= cor[CORDIC_STAGES].neg;
      den_m  <= pole_c ? DEN_W'(1) : cor[CORDIC_STAGES].xa[DEN_W-1:0];
      px_m   <= cor[CORDIC_STAGES].ya * cor[CORDIC_STAGES].yt;
      py_m   <= cor[CORDIC_STAGES].ya * cor[CORDIC_STAGES].xt;
    end
  end

  // magnitude, sign and overflow precheck
  div_t div [0:DIV_BITS];
  div_t div0_next;
  logic [PROD_W-1:0] mx, my;

  always_comb begin
    mx = px_m[PROD_W-1] ? PROD_W'(-px_m) : PROD_W'(px_m);
    my = py_m[PROD_W-1] ? PROD_W'(-py_m) : PROD_W'(py_m);
    div0_next.valid = valid_m;
    div0_next.pole  = pole_m;
    div0_next.den   = den_m;
    div0_next.rem_x = mx[REM_W-1:0];
    div0_next.q_x   = '0;
    div0_next.sgn_x = px_m[PROD_W-1] ^ neg_m;
    div0_next.ovf_x = (mx >> DIV_BITS) >= PROD_W'(den_m);
    div0_next.rem_y = my[REM_W-1:0];
    div0_next.q_y   = '0;
    div0_next.sgn_y = py_m[PROD_W-1] ^ neg_m;
    div0_next.ovf_y = (my >> DIV_BITS) >= PROD_W'(den_m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div[0].valid <= 1'b0;
    end else if (en) begin
      div[0].valid <= div0_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div[0].pole  <= div0_next.pole;
      div[0].den   <= div0_next.den;
      div[0].rem_x <= div0_next.rem_x;
      div[0].q_x   <= div0_next.q_x;
      div[0].sgn_x <= div0_next.sgn_x;
      div[0].ovf_x <= div0_next.ovf_x;
      div[0].rem_y <= div0_next.rem_y;
      div[0].q_y   <= div0_next.q_y;
      div[0].sgn_y <= div0_next.sgn_y;
      div[0].ovf_y <= div0_next.ovf_y;
    end
  end

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    lhg_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .shift (SH_W'(DIV_BITS - 1 - g)),
      .d_in  (div[g]),
      .d_out (div[g+1])
    );
  end

  // signed quotient times scaled radius
  div_t dq;
  logic valid_q, pole_q, big_x, big_y, sgn_x, sgn_y;
  logic signed [63:0] rx_q, ry_q;
  logic signed [QS_W-1:0] qx_s, qy_s;

  assign dq = div[DIV_BITS];

  always_comb begin
    qx_s = dq.sgn_x ? -QS_W'(dq.q_x) : QS_W'(dq.q_x);
    qy_s = dq.sgn_y ? -QS_W'(dq.q_y) : QS_W'(dq.q_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= dq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pole_q <= dq.pole;
      big_x  <= dq.ovf_x || (dq.q_x > QLIMIT);
      big_y  <= dq.ovf_y || (dq.q_y > QLIMIT);
      sgn_x  <= dq.sgn_x;
      sgn_y  <= dq.sgn_y;
      rx_q   <= 64'(qx_s * RE_Q16);
      ry_q   <= 64'(qy_s * RE_Q16);
    end
  end

  // round, offset, clamp
  logic signed [63:0] vx_r, vy_r;
  logic signed [V_W-1:0] vx, vy, gx, gy;
  logic flag;

  always_comb begin
    vx_r = (rx_q + (64'sd1 <<< 37)) >>> 38;
    vy_r = (ry_q + (64'sd1 <<< 37)) >>> 38;
    vx = vx_r[V_W-1:0] + OFF_X;
    vy = vy_r[V_W-1:0] + OFF_Y;
    flag = 1'b0;
    if (big_x) begin
      gx = sgn_x ? OUT_MIN : OUT_MAX;
      flag = 1'b1;
    end else if (vx > OUT_MAX) begin
      gx = OUT_MAX;
      flag = 1'b1;
    end else if (vx < OUT_MIN) begin
      gx = OUT_MIN;
      flag = 1'b1;
    end else begin
      gx = vx;
    end
    if (big_y) begin
      gy = sgn_y ? OUT_MIN : OUT_MAX;
      flag = 1'b1;
    end else if (vy > OUT_MAX) begin
      gy = OUT_MAX;
      flag = 1'b1;
    end else if (vy < OUT_MIN) begin
      gy = OUT_MIN;
      flag = 1'b1;
    end else begin
      gy = vy;
    end
    if (pole_q) begin
      gx = OUT_MAX;
      gy = OUT_MAX;
      flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {6'b0, gy[OUT_W-1:0], gx[OUT_W-1:0]};
      m_axis_tuser <= flag;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");
  a_rise_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(valid_q))
    else $error("result without pipeline request");
  a_pole_flag: assert property (@(posedge clk) disable iff (rst)
    valid_q && en && pole_q |=> m_axis_tuser)
    else $error("pole result not flagged");
`endif

endmodule
`default_nettype wire

[src/lhg_cordic_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lhg_cordic_cell
// One rotation-mode CORDIC iteration for both angles, registered.
// ----------------------------------------------------------------------------
module lhg_cordic_cell (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic [lhg_pkg::SH_W-1:0]        shift,
  input  wire logic signed [lhg_pkg::ANG_W-1:0] atan,
  input  wire lhg_pkg::cor_t                   d_in,
  output lhg_pkg::cor_t                        d_out
);
  import lhg_pkg::*;

  cor_t d_next;

  always_comb begin
    d_next = d_in;
    if (d_in.za >= 0) begin
      d_next.xa = d_in.xa - (d_in.ya >>> shift);
      d_next.ya = d_in.ya + (d_in.xa >>> shift);
      d_next.za = d_in.za - atan;
    end else begin
      d_next.xa = d_in.xa + (d_in.ya >>> shift);
      d_next.ya = d_in.ya - (d_in.xa >>> shift);
      d_next.za = d_in.za + atan;
    end
    if (d_in.zt >= 0) begin
      d_next.xt = d_in.xt - (d_in.yt >>> shift);
      d_next.yt = d_in.yt + (d_in.xt >>> shift);
      d_next.zt = d_in.zt - atan;
    end else begin
      d_next.xt = d_in.xt + (d_in.yt >>> shift);
      d_next.yt = d_in.yt - (d_in.xt >>> shift);
      d_next.zt = d_in.zt + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.pole <= d_next.pole;
      d_out.neg  <= d_next.neg;
      d_out.xa   <= d_next.xa;
      d_out.ya   <= d_next.ya;
      d_out.za   <= d_next.za;
      d_out.xt   <= d_next.xt;
      d_out.yt   <= d_next.yt;
      d_out.zt   <= d_next.zt;
    end
  end

endmodule
`default_nettype wire

[src/lhg_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lhg_div_cell
// One restoring-division quotient bit for both coordinate lanes, registered.
// ----------------------------------------------------------------------------
module lhg_div_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic [lhg_pkg::SH_W-1:0] shift,
  input  wire lhg_pkg::div_t            d_in,
  output lhg_pkg::div_t                 d_out
);
  import lhg_pkg::*;

  localparam int EXT_W = REM_W + 2;

  div_t d_next;
  logic [EXT_W-1:0] den_sh;

  always_comb begin
    d_next = d_in;
    den_sh = EXT_W'(d_in.den) << shift;
    if (!d_in.ovf_x && (EXT_W'(d_in.rem_x) >= den_sh)) begin
      d_next.rem_x = REM_W'(EXT_W'(d_in.rem_x) - den_sh);
      d_next.q_x   = d_in.q_x | (DIV_BITS'(1) << shift);
    end
    if (!d_in.ovf_y && (EXT_W'(d_in.rem_y) >= den_sh)) begin
      d_next.rem_y = REM_W'(EXT_W'(d_in.rem_y) - den_sh);
      d_next.q_y   = d_in.q_y | (DIV_BITS'(1) << shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.pole  <= d_next.pole;
      d_out.den   <= d_next.den;
      d_out.rem_x <= d_next.rem_x;
      d_out.q_x   <= d_next.q_x;
      d_out.sgn_x <= d_next.sgn_x;
      d_out.ovf_x <= d_next.ovf_x;
      d_out.rem_y <= d_next.rem_y;
      d_out.q_y   <= d_next.q_y;
      d_out.sgn_y <= d_next.sgn_y;
      d_out.ovf_y <= d_next.ovf_y;
    end
  end

`ifndef SYNTHESIS
  a_rem_x_below: assert property (@(posedge clk) disable iff (rst)
    d_out.valid && !d_out.ovf_x |->
      (EXT_W'(d_out.rem_x) < (EXT_W'(d_out.den) << shift)))
    else $error("x remainder not reduced");
  a_rem_y_below: assert property (@(posedge clk) disable iff (rst)
    d_out.valid && !d_out.ovf_y |->
      (EXT_W'(d_out.rem_y) < (EXT_W'(d_out.den) << shift)))
    else $error("y remainder not reduced");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    d_out.valid |-> (d_out.den != '0))
    else $error("zero divisor in divider");
`endif

endmodule
`default_nettype wire
